@@ sv/kdd_pkg.sv @@
// ----------------------------------------------------------------------------
// kdd_pkg
// Types and constants shared by the datapoint decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package kdd_pkg;

    // Result kinds as carried on the output tuser field.
    typedef enum logic [2:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_INT     = 3'd1,
        KIND_FIXED   = 3'd2,
        KIND_TEXT    = 3'd3,
        KIND_NAN     = 3'd4
    } kind_t;

    localparam int unsigned VALUE_W = 46;

    // Datapoint main type numbers.
    localparam logic [7:0] DPT_BOOL     = 8'd1;
    localparam logic [7:0] DPT_CTRL1    = 8'd2;
    localparam logic [7:0] DPT_CTRL3    = 8'd3;
    localparam logic [7:0] DPT_CHAR     = 8'd4;
    localparam logic [7:0] DPT_SCALING  = 8'd5;
    localparam logic [7:0] DPT_U16      = 8'd7;
    localparam logic [7:0] DPT_FLOAT16  = 8'd9;
    localparam logic [7:0] DPT_STRING   = 8'd16;

    // Payload lengths that each type requires.
    localparam logic [7:0] LEN_SMALL    = 8'd2;
    localparam logic [7:0] LEN_ONE_BYTE = 8'd3;
    localparam logic [7:0] LEN_TWO_BYTE = 8'd4;

    localparam logic [7:0] SMALL_MASK   = 8'h7f;
    localparam logic [7:0] NAN_HI       = 8'h7f;
    localparam logic [7:0] NAN_LO       = 8'hff;

    // Scaling type: q = floor(y / 510) computed as (y * PCT_RECIP) >> PCT_SHIFT,
    // exact for every 16-bit y.
    localparam int unsigned PCT_RECIP     = 65794;
    localparam int unsigned PCT_SHIFT     = 25;
    localparam int unsigned PCT_INT_STEP  = 25700;
    localparam int unsigned PCT_FRAC_MUL  = 200;
    localparam int unsigned PCT_FRAC_BIAS = 255;

    // Float type: floor(x / 25) as (x * F_RECIP) >> F_SHIFT, exact for x < 2^16.
    localparam int unsigned F_RECIP = 83887;
    localparam int unsigned F_SHIFT = 21;
    localparam int unsigned F_BIAS  = 12;

    typedef struct packed {
        kind_t                      kind;
        logic signed [VALUE_W-1:0]  value;
    } dec_res_t;

    // For p = 14 + e: c = floor(2^p / 25) and t = (2^p mod 25) * F_RECIP.
    typedef struct packed {
        logic [24:0] c;
        logic [20:0] t;
    } float_coef_t;

    function automatic float_coef_t float_coef(input logic [3:0] e);
        float_coef_t r;
        unique case (e)
            4'd0:  r = '{c: 25'd655,      t: 21'(9  * F_RECIP)};
            4'd1:  r = '{c: 25'd1310,     t: 21'(18 * F_RECIP)};
            4'd2:  r = '{c: 25'd2621,     t: 21'(11 * F_RECIP)};
            4'd3:  r = '{c: 25'd5242,     t: 21'(22 * F_RECIP)};
            4'd4:  r = '{c: 25'd10485,    t: 21'(19 * F_RECIP)};
            4'd5:  r = '{c: 25'd20971,    t: 21'(13 * F_RECIP)};
            4'd6:  r = '{c: 25'd41943,    t: 21'(1  * F_RECIP)};
            4'd7:  r = '{c: 25'd83886,    t: 21'(2  * F_RECIP)};
            4'd8:  r = '{c: 25'd167772,   t: 21'(4  * F_RECIP)};
            4'd9:  r = '{c: 25'd335544,   t: 21'(8  * F_RECIP)};
            4'd10: r = '{c: 25'd671088,   t: 21'(16 * F_RECIP)};
            4'd11: r = '{c: 25'd1342177,  t: 21'(7  * F_RECIP)};
            4'd12: r = '{c: 25'd2684354,  t: 21'(14 * F_RECIP)};
            4'd13: r = '{c: 25'd5368709,  t: 21'(3  * F_RECIP)};
            4'd14: r = '{c: 25'd10737418, t: 21'(6  * F_RECIP)};
            4'd15: r = '{c: 25'd21474836, t: 21'(12 * F_RECIP)};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/kdd_pct_scale.sv @@
// ----------------------------------------------------------------------------
// kdd_pct_scale
// Scales a one-byte value by 100/255 into Q16, rounding half upwards.
// ----------------------------------------------------------------------------
`default_nettype none

module kdd_pct_scale
    import kdd_pkg::*;
(
    input  wire logic [7:0]  byte_in,
    output logic [22:0]      q16
);

    // byte * 6553600 / 255 = byte * 25700 + byte * 100 / 255, so only the
    // small remainder term needs rounding: floor((200 * byte + 255) / 510).
    logic [15:0] frac_num;
    logic [32:0] frac_prod;
    logic [7:0]  frac_q;
    logic [22:0] int_part;

    assign frac_num  = 16'(byte_in) * 16'(PCT_FRAC_MUL) + 16'(PCT_FRAC_BIAS);
    assign frac_prod = 33'(frac_num) * 33'(PCT_RECIP);
    assign frac_q    = frac_prod[PCT_SHIFT +: 8];
    assign int_part  = 23'(byte_in) * 23'(PCT_INT_STEP);
    assign q16       = int_part + 23'(frac_q);

endmodule

`default_nettype wire

@@ sv/kdd_float_conv.sv @@
// ----------------------------------------------------------------------------
// kdd_float_conv
// Converts a 2-byte bus float, 0.01 * M * 2^E, into a signed Q16 value.
// ----------------------------------------------------------------------------
`default_nettype none

module kdd_float_conv
    import kdd_pkg::*;
(
    input  wire logic [7:0]            hi,
    input  wire logic [7:0]            lo,
    output logic signed [VALUE_W-1:0]  q16
);

    // Result magnitude is round(|M| * 2^(16+E) / 100), which equals
    // floor((|M| * 2^p + 12) / 25) with p = 14 + E.  Splitting 2^p into
    // 25 * c + r leaves |M| * c plus a small quotient of (|M| * r + 12) / 25.
    logic        neg;
    logic [3:0]  expo;
    logic [10:0] mant;
    logic [11:0] mag;
    float_coef_t coef;
    logic [36:0] prod_c;
    logic [33:0] prod_t;
    logic [12:0] frac_q;
    logic [36:0] mag_q;

    assign neg  = hi[7];
    assign expo = hi[6:3];
    assign mant = {hi[2:0], lo};

    // A negative mantissa of zero stands for -2048.
    assign mag  = neg ? (12'd2048 - 12'(mant)) : 12'(mant);
    assign coef = float_coef(expo);

    assign prod_c = 37'(mag) * 37'(coef.c);
    assign prod_t = 34'(mag) * 34'(coef.t) + 34'(F_BIAS * F_RECIP);
    assign frac_q = prod_t[F_SHIFT +: 13];
    assign mag_q  = prod_c + 37'(frac_q);

    assign q16 = neg ? -$signed(VALUE_W'(mag_q)) : $signed(VALUE_W'(mag_q));

endmodule

`default_nettype wire

@@ sv/kdd_decode.sv @@
// ----------------------------------------------------------------------------
// kdd_decode
// Selects the decoding rule for one telegram from the configured main type.
// ----------------------------------------------------------------------------
`default_nettype none

module kdd_decode
    import kdd_pkg::*;
(
    input  wire logic [7:0] dpt_major,
    input  wire logic [7:0] payload_len,
    input  wire logic [7:0] payload_byte1,
    input  wire logic [7:0] payload_byte2,
    input  wire logic [7:0] payload_byte3,
    output dec_res_t        res
);

    logic [22:0]               pct_q16;
    logic signed [VALUE_W-1:0] flt_q16;

    kdd_pct_scale u_pct (
        .byte_in (payload_byte2),
        .q16     (pct_q16)
    );

    kdd_float_conv u_flt (
        .hi  (payload_byte2),
        .lo  (payload_byte3),
        .q16 (flt_q16)
    );

    always_comb
    begin
        res.kind  = KIND_UNKNOWN;
        res.value = '0;
        unique case (dpt_major)
            DPT_BOOL, DPT_CTRL1, DPT_CTRL3:
            begin
                if (payload_len == LEN_SMALL)
                begin
                    res.kind  = KIND_INT;
                    res.value = VALUE_W'(payload_byte1 & SMALL_MASK);
                end
            end
            DPT_SCALING:
            begin
                if (payload_len == LEN_ONE_BYTE)
                begin
                    res.kind  = KIND_FIXED;
                    res.value = VALUE_W'(pct_q16);
                end
            end
            DPT_U16:
            begin
                if (payload_len == LEN_TWO_BYTE)
                begin
                    res.kind  = KIND_INT;
                    res.value = VALUE_W'({payload_byte2, payload_byte3});
                end
            end
            DPT_FLOAT16:
            begin
                if (payload_len == LEN_TWO_BYTE)
                begin
                    if (payload_byte2 == NAN_HI && payload_byte3 == NAN_LO)
                    begin
                        res.kind = KIND_NAN;
                    end
                    else
                    begin
                        res.kind  = KIND_FIXED;
                        res.value = flt_q16;
                    end
                end
            end
            DPT_CHAR, DPT_STRING:
            begin
                res.kind = KIND_TEXT;
            end
            default:
            begin
                res.kind  = KIND_UNKNOWN;
                res.value = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/knx_datapoint_decoder.sv @@
// ----------------------------------------------------------------------------
// knx_datapoint_decoder
// Decodes group telegram payloads according to a configured datapoint type.
//
// Input stream (s_t*): one telegram per transaction, tdata holds the payload
// length and payload bytes 1 to 3.  Output stream (m_t*): one result per
// telegram, tuser gives the kind and tdata the value.  The main type is
// written through cfg_we/cfg_wdata; the user must write it only while no
// telegram is in flight; the block itself does not enforce this.  A taken
// telegram enters the input register, is decoded and is captured in the
// result register, where m_tvalid rises, once that register can take it.
// The block takes one telegram every cycle while the receiver does not stall;
// its rate is set by the single decode stage, whose float path uses two
// parallel multipliers of at most 12 by 25 bits.  When the receiver stalls,
// the result register holds its transaction and the input register may
// still take one more telegram; s_tready then falls until the result moves
// on.  Reset empties both registers and sets the main type to zero, so every
// telegram decodes as unknown until it is written.
`default_nettype none

module knx_datapoint_decoder
    import kdd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] payload_len, [15:8] payload_byte1, [23:16] payload_byte2,
    // [31:24] payload_byte3
    input  wire logic [31:0] s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [45:0] value (two's complement), [47:46] zero
    output logic [47:0]      m_tdata,
    // [2:0] value_kind
    output logic [2:0]       m_tuser,

    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata
);

    logic [7:0]  dpt_major_reg;

    // Input register stage.
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] in_data_reg;

    // Result register stage.
    logic        out_valid_reg;
    logic        out_valid_next;
    dec_res_t    out_res_reg;

    logic        out_load;
    logic        in_load;
    dec_res_t    dec_res;

    // The result register can take new data when it is empty or being read;
    // the input register can then always pass its content on.
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpt_major_reg <= '0;
        end
        else if (cfg_we)
        begin
            dpt_major_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= s_tdata;
        end
    end

    kdd_decode u_decode (
        .dpt_major     (dpt_major_reg),
        .payload_len   (in_data_reg[7:0]),
        .payload_byte1 (in_data_reg[15:8]),
        .payload_byte2 (in_data_reg[23:16]),
        .payload_byte3 (in_data_reg[31:24]),
        .res           (dec_res)
    );

    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            out_res_reg <= dec_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.value};
    assign m_tuser  = out_res_reg.kind;

endmodule

`default_nettype wire

@@ sv/kdd_checker.sv @@
// ----------------------------------------------------------------------------
// kdd_checker
// Port-level checks on the datapoint decoder, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kdd_checker
    import kdd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // A stalled result keeps its value and kind.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Only integer and fixed-point results carry a value.
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_INT && m_tuser != KIND_FIXED |-> m_tdata == '0)
        else $error("non-numeric result carries a value");

    // Integers never exceed 16 bits.
    a_int_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_INT |-> m_tdata[47:16] == '0)
        else $error("integer result out of range");

    // Reset leaves no result pending once it has been seen by a clock edge.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // An offered telegram stays unchanged until it is taken.
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("telegram changed while waiting");

endmodule

bind knx_datapoint_decoder kdd_checker u_kdd_checker (.*);

`default_nettype wire

@@ tb/sv/kdd_checker.sv @@
// ----------------------------------------------------------------------------
// kdd_scoreboard
// Watches both streams and the configuration port of the datapoint decoder.
// It predicts the result of every telegram and compares each result with
// the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module kdd_scoreboard
    import kdd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    input  wire logic [2:0]  m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata,
    output int               mismatches,
    output int               outstanding,
    output int               compared
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0] main_type;
    dec_res_t   decoded_q[$];
    int         fail_count;
    int         result_count;

    // Two-byte float: sign, 4-bit exponent and 11-bit mantissa. The magnitude
    // in Q16 is rounded half away from zero before the sign goes back on.
    function automatic logic [VALUE_W-1:0] float16_q16(input logic [7:0] hi,
                                                      input logic [7:0] lo);
        logic [3:0]        expo;
        logic [10:0]       mant;
        longint unsigned   mag;
        longint unsigned   q;
        expo = hi[6:3];
        mant = {hi[2:0], lo};
        // A set sign bit with a zero mantissa stands for -2048.
        mag  = hi[7] ? 64'd2048 - 64'(mant) : 64'(mant);
        q    = ((mag << (16 + expo)) + 64'd50) / 64'd100;
        if (hi[7])
        begin
            q = -q;
        end
        return q[VALUE_W-1:0];
    endfunction

    function automatic dec_res_t decode_telegram(input logic [7:0]  dpt,
                                                 input logic [31:0] word);
        dec_res_t   res;
        logic [7:0] len;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        len = word[7:0];
        b1  = word[15:8];
        b2  = word[23:16];
        b3  = word[31:24];
        res.kind  = KIND_UNKNOWN;
        res.value = '0;
        case (dpt)
            DPT_BOOL, DPT_CTRL1, DPT_CTRL3:
            begin
                if (len == LEN_SMALL)
                begin
                    res.kind  = KIND_INT;
                    res.value = VALUE_W'(b1 & SMALL_MASK);
                end
            end
            DPT_SCALING:
            begin
                if (len == LEN_ONE_BYTE)
                begin
                    res.kind  = KIND_FIXED;
                    res.value = VALUE_W'((64'(b2) * 64'd13107200 + 64'd255) / 64'd510);
                end
            end
            DPT_U16:
            begin
                if (len == LEN_TWO_BYTE)
                begin
                    res.kind  = KIND_INT;
                    res.value = VALUE_W'({b2, b3});
                end
            end
            DPT_FLOAT16:
            begin
                if (len == LEN_TWO_BYTE)
                begin
                    if (b2 == NAN_HI && b3 == NAN_LO)
                    begin
                        res.kind = KIND_NAN;
                    end
                    else
                    begin
                        res.kind  = KIND_FIXED;
                        res.value = float16_q16(b2, b3);
                    end
                end
            end
            DPT_CHAR, DPT_STRING:
            begin
                res.kind = KIND_TEXT;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic flag(input string what, input logic [47:0] want_v,
                        input logic [47:0] got_v);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%0t ns: %s: expected %h, got %h", $time, what, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dec_res_t want;
        if (!rst_n)
        begin
            main_type = '0;
            decoded_q.delete();
            fail_count   = 0;
            result_count = 0;
            mismatches  <= 0;
            outstanding <= 0;
            compared    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                decoded_q.push_back(decode_telegram(main_type, s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    flag("result with no telegram waiting", '0, m_tdata);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    result_count++;
                    if (m_tuser !== want.kind)
                    begin
                        flag("value_kind", 48'(want.kind), 48'(m_tuser));
                    end
                    if (m_tdata !== {2'b00, want.value})
                    begin
                        flag("value", {2'b00, want.value}, m_tdata);
                    end
                end
            end
            // The register takes effect for telegrams after this edge.
            if (cfg_we)
            begin
                main_type = cfg_wdata;
            end
            mismatches  <= fail_count;
            outstanding <= decoded_q.size();
            compared    <= result_count;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the datapoint decoder.
//
// A short directed list walks through every main type, the field extremes,
// wrong lengths, the not-a-number pattern and the negative zero mantissa.
// Random phases then follow, each under its own main type, with mostly
// correctly sized telegrams. Both sides idle at random; one phase runs with
// no idling and a long receiver hold-off so that the decoder fills and stalls
// its input. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    import kdd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASE_COUNT  = 14;
    localparam int PHASE_ITEMS  = 50;
    localparam int IDLE_PERCENT = 38;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    int          mismatches;
    int          outstanding;
    int          compared;

    // Shared between the stimulus and the receiver process. Both are written
    // with nonblocking assignments so that the receiver sees them race-free.
    logic        calm        = 1'b0;
    int          hold_asked  = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;

    logic [7:0]  current_type = '0;
    int          telegrams    = 0;
    int          type_writes  = 0;
    int          cycle_count  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    knx_datapoint_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    kdd_scoreboard u_scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    // Receiver: random back-pressure, none at all in the calm phase, and a
    // long hold-off, counted here, whenever the stimulus asks for one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen <= hold_asked;
            hold_left <= HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Watchdog: a run that stops making progress ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Offers one telegram and returns at the edge where the transaction is
    // taken. tvalid is left high so that a following telegram can go
    // straight out on the next cycle.
    task automatic send_telegram(input logic [31:0] word);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        telegrams++;
    endtask

    // Stops offering and waits until every telegram in flight has produced
    // its result. The first edge lets the checker count a transaction that
    // was taken at the edge on which this task was entered.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // The main type is only changed while the decoder holds no telegram.
    task automatic set_type(input logic [7:0] dpt);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= dpt;
        @(posedge clk);
        cfg_we       <= 1'b0;
        current_type  = dpt;
        type_writes++;
    endtask

    task automatic directed(input logic [7:0] dpt, input logic [7:0] len,
                            input logic [7:0] b1, input logic [7:0] b2,
                            input logic [7:0] b3);
        if (dpt != current_type)
        begin
            set_type(dpt);
        end
        send_telegram({b3, b2, b1, len});
    endtask

    // Most telegrams carry the length that the current type needs, so that
    // the decoding paths themselves are exercised; the rest have a length
    // chosen at random, either small or from the whole range.
    function automatic logic [31:0] random_telegram(input logic [7:0] dpt);
        logic [7:0] len;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        int         pick;
        b1 = 8'($urandom);
        b2 = 8'($urandom);
        b3 = 8'($urandom);
        case (dpt)
            DPT_BOOL, DPT_CTRL1, DPT_CTRL3: len = LEN_SMALL;
            DPT_SCALING:                    len = LEN_ONE_BYTE;
            DPT_U16, DPT_FLOAT16:           len = LEN_TWO_BYTE;
            default:                        len = 8'($urandom_range(0, 255));
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            len = 8'($urandom_range(0, 255));
        end
        else if (pick < 22)
        begin
            len = 8'($urandom_range(0, 6));
        end
        if (dpt == DPT_FLOAT16)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                // The not-a-number pattern.
                b2 = NAN_HI;
                b3 = NAN_LO;
            end
            else if (pick < 12)
            begin
                // Negative sign over a zero mantissa, any exponent.
                b2 = {1'b1, 4'($urandom), 3'b000};
                b3 = 8'h00;
            end
            else if (pick < 16)
            begin
                // Right next to the not-a-number pattern.
                b2 = NAN_HI;
            end
        end
        return {b3, b2, b1, len};
    endfunction

    initial
    begin
        logic [7:0] plan [PHASE_COUNT];

        plan = '{DPT_FLOAT16, DPT_SCALING, DPT_U16, DPT_BOOL, DPT_CTRL1, DPT_CTRL3,
                 DPT_CHAR, DPT_STRING, 8'd0, 8'd255, 8'd0, DPT_FLOAT16,
                 DPT_SCALING, 8'd0};
        plan[10] = 8'($urandom_range(0, 255));
        plan[13] = 8'($urandom_range(0, 255));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first telegram runs under the type left by reset.
        directed(8'd0,        LEN_SMALL,    8'hff, 8'h00, 8'h00);
        directed(DPT_BOOL,    LEN_SMALL,    8'hff, 8'h00, 8'h00);
        directed(DPT_BOOL,    LEN_SMALL,    8'h00, 8'hff, 8'hff);
        directed(DPT_BOOL,    LEN_ONE_BYTE, 8'h05, 8'h00, 8'h00);
        directed(DPT_CTRL1,   LEN_SMALL,    8'h80, 8'h55, 8'haa);
        directed(DPT_CTRL3,   LEN_SMALL,    8'h7f, 8'h00, 8'h00);
        directed(DPT_CHAR,    8'd0,         8'h00, 8'h00, 8'h00);
        directed(DPT_CHAR,    8'd255,       8'hff, 8'hff, 8'hff);
        directed(DPT_SCALING, LEN_ONE_BYTE, 8'h00, 8'h00, 8'h00);
        directed(DPT_SCALING, LEN_ONE_BYTE, 8'hff, 8'hff, 8'hff);
        directed(DPT_SCALING, LEN_ONE_BYTE, 8'h00, 8'h80, 8'h00);
        directed(DPT_SCALING, LEN_SMALL,    8'h00, 8'h80, 8'h00);
        directed(DPT_U16,     LEN_TWO_BYTE, 8'h00, 8'h00, 8'h00);
        directed(DPT_U16,     LEN_TWO_BYTE, 8'h00, 8'hff, 8'hff);
        directed(DPT_U16,     8'd5,         8'h00, 8'h12, 8'h34);
        // Not-a-number, negative zero mantissa at both exponent ends, the
        // largest positive value, minus one at the largest exponent, the
        // smallest positive step and the not-a-number bytes at a wrong length.
        directed(DPT_FLOAT16, LEN_TWO_BYTE, 8'h00, NAN_HI, NAN_LO);
        directed(DPT_FLOAT16, LEN_TWO_BYTE, 8'h00, 8'h80, 8'h00);
        directed(DPT_FLOAT16, LEN_TWO_BYTE, 8'h00, 8'hf8, 8'h00);
        directed(DPT_FLOAT16, LEN_TWO_BYTE, 8'hff, 8'h7f, 8'hfe);
        directed(DPT_FLOAT16, LEN_TWO_BYTE, 8'h00, 8'hff, 8'hff);
        directed(DPT_FLOAT16, LEN_TWO_BYTE, 8'h00, 8'h00, 8'h01);
        directed(DPT_FLOAT16, LEN_ONE_BYTE, 8'h00, NAN_HI, NAN_LO);
        directed(DPT_STRING,  LEN_TWO_BYTE, 8'h41, 8'h42, 8'h43);
        directed(8'd255,      LEN_SMALL,    8'h01, 8'h00, 8'h00);

        // Random phases, one main type each.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            set_type(plan[p]);
            if (p == 3)
            begin
                // No idling on either side, and the receiver holds off while
                // the sender keeps offering, so the input stalls.
                calm       <= 1'b1;
                hold_asked <= hold_asked + 1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_telegram(random_telegram(current_type));
            end
            if (p == 3)
            begin
                calm <= 1'b0;
            end
        end

        drain();
        // Room for any stray result that is still on its way.
        repeat (4) @(posedge clk);

        $display("Sent %0d telegrams over %0d main-type writes, with random idling",
                 telegrams, type_writes);
        $display("and a %0d-cycle receiver hold-off; %0d results were checked.",
                 HOLD_CYCLES, compared);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
